// ===== hdl/brs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brs_pkg
// Shared constants and types for the blob run statistics block.
// ----------------------------------------------------------------------------
package brs_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int FRAC_BITS_DEF  = 8;

    // Configuration register map
    localparam int CFG_INDEX_BITS = 1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_HEIGHT = 1'b1;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_LX,
        ST_MUL_LL,
        ST_MUL_LY,
        ST_ADD_Y,
        ST_DIV_X_GO,
        ST_DIV_X,
        ST_DIV_Y_GO,
        ST_DIV_Y,
        ST_EMIT
    } state_t;

    // Accumulator unit operations
    typedef enum logic [2:0] {
        ACC_HOLD,
        ACC_FIRST,
        ACC_MUL_LL,
        ACC_MUL_LY,
        ACC_ADD_Y,
        ACC_CLEAR
    } acc_op_t;

    typedef struct packed {
        acc_op_t op;
    } acc_ctrl_t;

endpackage

`default_nettype wire

// ===== hdl/brs_divider.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brs_divider
// Bit-serial restoring divider giving floor(dividend * 2^FRAC_BITS / divisor),
// saturated to QUOT_BITS, and zero for a zero divisor. One bit per cycle.
// ----------------------------------------------------------------------------
module brs_divider #(
    parameter int DIVIDEND_BITS = 37,
    parameter int DIVISOR_BITS  = 25,
    parameter int QUOT_BITS     = 20,
    parameter int FRAC_BITS     = 8
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    input  wire logic [DIVIDEND_BITS-1:0] dividend,
    input  wire logic [DIVISOR_BITS-1:0]  divisor,
    output logic                          done,
    output logic [QUOT_BITS-1:0]          quotient
);

    localparam int STEPS      = DIVIDEND_BITS + FRAC_BITS;
    localparam int CNT_BITS   = $clog2(STEPS);
    localparam int HIGH_STEPS = STEPS - QUOT_BITS;

    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;
    logic [CNT_BITS-1:0]     cnt_reg, cnt_next;
    logic [STEPS-1:0]        num_reg, num_next;
    logic [DIVISOR_BITS-1:0] den_reg, den_next;
    logic [DIVISOR_BITS-1:0] rem_reg, rem_next;
    logic [QUOT_BITS-1:0]    quot_reg, quot_next;
    logic                    ovf_reg, ovf_next;
    logic                    zero_reg, zero_next;

    logic [DIVISOR_BITS:0]   trial;
    logic [DIVISOR_BITS:0]   diff;
    logic                    fits;

    assign trial = {rem_reg, num_reg[STEPS-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign fits  = (trial >= {1'b0, den_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        quot_next = quot_reg;
        ovf_next  = ovf_reg;
        zero_next = zero_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            num_next  = STEPS'(dividend) << FRAC_BITS;
            den_next  = divisor;
            rem_next  = '0;
            quot_next = '0;
            ovf_next  = 1'b0;
            zero_next = (divisor == '0);
        end
        else if (busy_reg)
        begin
            num_next  = num_reg << 1;
            rem_next  = fits ? diff[DIVISOR_BITS-1:0] : trial[DIVISOR_BITS-1:0];
            quot_next = (quot_reg << 1) | QUOT_BITS'(fits);
            // a set bit above the quotient width means saturation
            ovf_next  = ovf_reg | (fits && (cnt_reg < CNT_BITS'(HIGH_STEPS)));
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == CNT_BITS'(STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg  <= num_next;
        den_reg  <= den_next;
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        ovf_reg  <= ovf_next;
        zero_reg <= zero_next;
    end

    assign done     = done_reg;
    assign quotient = zero_reg ? '0 : (ovf_reg ? '1 : quot_reg);

endmodule

`default_nettype wire

// ===== hdl/brs_accum.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brs_accum
// Blob accumulators: box, area, border flag and the x and y coordinate sums,
// built around one shared multiplier and one saturating sum adder.
// ----------------------------------------------------------------------------
module brs_accum
    import brs_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire acc_ctrl_t                 ctrl,
    input  wire logic [COORD_BITS-1:0]     run_x,
    input  wire logic [COORD_BITS-1:0]     run_y,
    input  wire logic [COORD_BITS:0]       run_len,
    input  wire logic [COORD_BITS:0]       image_width,
    input  wire logic [COORD_BITS:0]       image_height,
    output logic [COORD_BITS-1:0]          min_x,
    output logic [COORD_BITS-1:0]          max_x,
    output logic [COORD_BITS-1:0]          min_y,
    output logic [COORD_BITS-1:0]          max_y,
    output logic [2*COORD_BITS:0]          area,
    output logic [3*COORD_BITS:0]          x_sum,
    output logic [3*COORD_BITS:0]          y_sum,
    output logic                           border
);

    localparam int AREA_BITS = 2 * COORD_BITS + 1;
    localparam int SUM_BITS  = 3 * COORD_BITS + 1;
    localparam int PROD_BITS = 2 * COORD_BITS + 2;

    logic [COORD_BITS-1:0] min_x_reg, min_x_next;
    logic [COORD_BITS-1:0] max_x_reg, max_x_next;
    logic [COORD_BITS-1:0] min_y_reg, min_y_next;
    logic [COORD_BITS-1:0] max_y_reg, max_y_next;
    logic [AREA_BITS-1:0]  area_reg, area_next;
    logic [SUM_BITS-1:0]   x_sum_reg, x_sum_next;
    logic [SUM_BITS-1:0]   y_sum_reg, y_sum_next;
    logic                  border_reg, border_next;
    logic [PROD_BITS-1:0]  prod_reg, prod_next;

    logic [COORD_BITS:0]   mul_a;
    logic [COORD_BITS:0]   mul_b;
    logic [PROD_BITS-1:0]  product;
    logic [SUM_BITS-1:0]   add_base;
    logic [SUM_BITS-1:0]   add_operand;
    logic [SUM_BITS:0]     add_full;
    logic [SUM_BITS-1:0]   add_sat;
    logic [AREA_BITS:0]    area_full;
    logic [AREA_BITS-1:0]  area_sat;
    logic [COORD_BITS:0]   end_excl;
    logic [COORD_BITS:0]   end_incl;
    logic [COORD_BITS-1:0] run_end;
    logic                  hit_edge;

    assign product   = PROD_BITS'(mul_a) * PROD_BITS'(mul_b);
    assign add_full  = {1'b0, add_base} + {1'b0, add_operand};
    assign add_sat   = add_full[SUM_BITS] ? '1 : add_full[SUM_BITS-1:0];
    assign area_full = {1'b0, area_reg} + (AREA_BITS + 1)'(run_len);
    assign area_sat  = area_full[AREA_BITS] ? '1 : area_full[AREA_BITS-1:0];
    assign end_excl  = {1'b0, run_x} + run_len;
    assign end_incl  = end_excl - 1'b1;
    assign run_end   = end_incl[COORD_BITS-1:0];
    assign hit_edge  = (run_y == '0) || (({1'b0, run_y} + 1'b1) == image_height)
                    || (run_x == '0) || (end_excl == image_width);

    always_comb
    begin
        min_x_next  = min_x_reg;
        max_x_next  = max_x_reg;
        min_y_next  = min_y_reg;
        max_y_next  = max_y_reg;
        area_next   = area_reg;
        x_sum_next  = x_sum_reg;
        y_sum_next  = y_sum_reg;
        border_next = border_reg;
        prod_next   = prod_reg;
        mul_a       = run_len;
        mul_b       = {1'b0, run_x};
        add_base    = x_sum_reg;
        add_operand = SUM_BITS'(prod_reg);
        case (ctrl.op)
            ACC_FIRST:
            begin
                // box, area and edge test; first product len * x
                if (run_x < min_x_reg)
                    min_x_next = run_x;
                if (run_end > max_x_reg)
                    max_x_next = run_end;
                if (run_y < min_y_reg)
                    min_y_next = run_y;
                if (run_y > max_y_reg)
                    max_y_next = run_y;
                area_next = area_sat;
                if (hit_edge)
                    border_next = 1'b1;
                prod_next = product;
            end
            ACC_MUL_LL:
            begin
                x_sum_next = add_sat;
                mul_b      = run_len - 1'b1;
                prod_next  = product;
            end
            ACC_MUL_LY:
            begin
                // half of len * (len - 1) completes the run's x sum
                add_operand = SUM_BITS'(prod_reg >> 1);
                x_sum_next  = add_sat;
                mul_b       = {1'b0, run_y};
                prod_next   = product;
            end
            ACC_ADD_Y:
            begin
                add_base   = y_sum_reg;
                y_sum_next = add_sat;
            end
            ACC_CLEAR:
            begin
                min_x_next  = '1;
                max_x_next  = '0;
                min_y_next  = '1;
                max_y_next  = '0;
                area_next   = '0;
                x_sum_next  = '0;
                y_sum_next  = '0;
                border_next = 1'b0;
            end
            default:
            begin
                prod_next = prod_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_x_reg  <= '1;
            max_x_reg  <= '0;
            min_y_reg  <= '1;
            max_y_reg  <= '0;
            area_reg   <= '0;
            x_sum_reg  <= '0;
            y_sum_reg  <= '0;
            border_reg <= 1'b0;
        end
        else
        begin
            min_x_reg  <= min_x_next;
            max_x_reg  <= max_x_next;
            min_y_reg  <= min_y_next;
            max_y_reg  <= max_y_next;
            area_reg   <= area_next;
            x_sum_reg  <= x_sum_next;
            y_sum_reg  <= y_sum_next;
            border_reg <= border_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign min_x  = min_x_reg;
    assign max_x  = max_x_reg;
    assign min_y  = min_y_reg;
    assign max_y  = max_y_reg;
    assign area   = area_reg;
    assign x_sum  = x_sum_reg;
    assign y_sum  = y_sum_reg;
    assign border = border_reg;

endmodule

`default_nettype wire

// ===== hdl/blob_run_statistics.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// blob_run_statistics
// Run-length blob statistics: bounding box, area, midpoint, fixed-point
// centroid and image border flag, one result per blob.
// ----------------------------------------------------------------------------
// Each input transaction is one horizontal run. A run of non-zero length is
// accepted and then takes four steps of the shared multiplier and sum adder
// (MUL_LX, MUL_LL, MUL_LY, ADD_Y); a zero-length run ends at acceptance. On
// the blob's last run the two centroids follow through one shared bit-serial
// divider, x and then y, each after a start state of its own. in_ready is
// low throughout. The result sits in an output register, so the next blob's
// runs are taken while it waits; a later result waits only for that register.
// ----------------------------------------------------------------------------
module blob_run_statistics
    import brs_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // configuration write channel
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [CFG_INDEX_BITS-1:0]       cfg_index,
    input  wire logic [COORD_BITS:0]             cfg_data,
    // run input channel
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [COORD_BITS-1:0]           run_start_x,
    input  wire logic [COORD_BITS-1:0]           run_row,
    input  wire logic [COORD_BITS:0]             run_length,
    input  wire logic                            blob_last,
    // result channel
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic [COORD_BITS-1:0]                box_min_x,
    output logic [COORD_BITS-1:0]                box_min_y,
    output logic [COORD_BITS-1:0]                box_max_x,
    output logic [COORD_BITS-1:0]                box_max_y,
    output logic [2*COORD_BITS:0]                blob_area,
    output logic [COORD_BITS-1:0]                mid_x,
    output logic [COORD_BITS-1:0]                mid_y,
    output logic [COORD_BITS+FRAC_BITS-1:0]      centroid_x,
    output logic [COORD_BITS+FRAC_BITS-1:0]      centroid_y,
    output logic                                 touches_border
);

    localparam int AREA_BITS = 2 * COORD_BITS + 1;
    localparam int SUM_BITS  = 3 * COORD_BITS + 1;
    localparam int CENT_BITS = COORD_BITS + FRAC_BITS;
    localparam logic [COORD_BITS:0] FULL_SPAN = (COORD_BITS + 1)'(1) << COORD_BITS;

    state_t state_reg, state_next;

    logic [COORD_BITS:0]     width_reg, width_next;
    logic [COORD_BITS:0]     height_reg, height_next;
    logic [COORD_BITS-1:0]   x_reg, x_next;
    logic [COORD_BITS-1:0]   y_reg, y_next;
    logic [COORD_BITS:0]     len_reg, len_next;
    logic                    last_reg, last_next;
    logic [CENT_BITS-1:0]    cent_x_reg, cent_x_next;
    logic                    out_valid_reg, out_valid_next;

    logic [COORD_BITS-1:0]   o_min_x_reg, o_min_x_next;
    logic [COORD_BITS-1:0]   o_min_y_reg, o_min_y_next;
    logic [COORD_BITS-1:0]   o_max_x_reg, o_max_x_next;
    logic [COORD_BITS-1:0]   o_max_y_reg, o_max_y_next;
    logic [AREA_BITS-1:0]    o_area_reg, o_area_next;
    logic [COORD_BITS-1:0]   o_mid_x_reg, o_mid_x_next;
    logic [COORD_BITS-1:0]   o_mid_y_reg, o_mid_y_next;
    logic [CENT_BITS-1:0]    o_cent_x_reg, o_cent_x_next;
    logic [CENT_BITS-1:0]    o_cent_y_reg, o_cent_y_next;
    logic                    o_border_reg, o_border_next;

    logic                    in_fire;
    logic [COORD_BITS:0]     room;
    logic [COORD_BITS:0]     len_clip;
    logic                    out_free;
    logic                    out_load;
    logic                    div_start;
    logic                    div_sel_y;
    logic                    div_done;
    logic [SUM_BITS-1:0]     div_dividend;
    logic [CENT_BITS-1:0]    div_quotient;
    acc_ctrl_t               acc_ctrl;

    logic [COORD_BITS-1:0]   acc_min_x;
    logic [COORD_BITS-1:0]   acc_max_x;
    logic [COORD_BITS-1:0]   acc_min_y;
    logic [COORD_BITS-1:0]   acc_max_y;
    logic [AREA_BITS-1:0]    acc_area;
    logic [SUM_BITS-1:0]     acc_x_sum;
    logic [SUM_BITS-1:0]     acc_y_sum;
    logic                    acc_border;
    logic [COORD_BITS:0]     mid_x_full;
    logic [COORD_BITS:0]     mid_y_full;

    assign in_fire   = in_valid && in_ready;
    // cut the run so that it ends at the last column that COORD_BITS can hold
    assign room      = FULL_SPAN - {1'b0, run_start_x};
    assign len_clip  = (run_length > room) ? room : run_length;
    assign out_free  = !out_valid_reg || out_ready;
    assign cfg_ready = 1'b1;

    assign div_dividend = div_sel_y ? acc_y_sum : acc_x_sum;
    assign mid_x_full   = ({1'b0, acc_min_x} + {1'b0, acc_max_x}) >> 1;
    assign mid_y_full   = ({1'b0, acc_min_y} + {1'b0, acc_max_y}) >> 1;

    brs_accum #(
        .COORD_BITS   (COORD_BITS)
    ) u_accum (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (acc_ctrl),
        .run_x        (x_reg),
        .run_y        (y_reg),
        .run_len      (len_reg),
        .image_width  (width_reg),
        .image_height (height_reg),
        .min_x        (acc_min_x),
        .max_x        (acc_max_x),
        .min_y        (acc_min_y),
        .max_y        (acc_max_y),
        .area         (acc_area),
        .x_sum        (acc_x_sum),
        .y_sum        (acc_y_sum),
        .border       (acc_border)
    );

    brs_divider #(
        .DIVIDEND_BITS (SUM_BITS),
        .DIVISOR_BITS  (AREA_BITS),
        .QUOT_BITS     (CENT_BITS),
        .FRAC_BITS     (FRAC_BITS)
    ) u_divider (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (div_start),
        .dividend      (div_dividend),
        .divisor       (acc_area),
        .done          (div_done),
        .quotient      (div_quotient)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (len_clip != '0)
                        state_next = ST_MUL_LX;
                    else if (blob_last)
                        state_next = ST_DIV_X_GO;
                end
            end
            ST_MUL_LX:   state_next = ST_MUL_LL;
            ST_MUL_LL:   state_next = ST_MUL_LY;
            ST_MUL_LY:   state_next = ST_ADD_Y;
            ST_ADD_Y:    state_next = last_reg ? ST_DIV_X_GO : ST_IDLE;
            ST_DIV_X_GO: state_next = ST_DIV_X;
            ST_DIV_X:
            begin
                if (div_done)
                    state_next = ST_DIV_Y_GO;
            end
            ST_DIV_Y_GO: state_next = ST_DIV_Y;
            ST_DIV_Y:
            begin
                if (div_done)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        in_ready      = 1'b0;
        acc_ctrl.op   = ACC_HOLD;
        div_start     = 1'b0;
        div_sel_y     = 1'b0;
        out_load      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready      = 1'b1;
            end
            ST_MUL_LX:   acc_ctrl.op = ACC_FIRST;
            ST_MUL_LL:   acc_ctrl.op = ACC_MUL_LL;
            ST_MUL_LY:   acc_ctrl.op = ACC_MUL_LY;
            ST_ADD_Y:    acc_ctrl.op = ACC_ADD_Y;
            ST_DIV_X_GO: div_start = 1'b1;
            ST_DIV_X:    div_sel_y = 1'b0;
            ST_DIV_Y_GO:
            begin
                div_start = 1'b1;
                div_sel_y = 1'b1;
            end
            ST_DIV_Y:    div_sel_y = 1'b1;
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_load    = 1'b1;
                    acc_ctrl.op = ACC_CLEAR;
                end
            end
            default:     acc_ctrl.op = ACC_HOLD;
        endcase
    end

    // registers, run capture and result register
    always_comb
    begin
        width_next     = width_reg;
        height_next    = height_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        len_next       = len_reg;
        last_next      = last_reg;
        cent_x_next    = cent_x_reg;
        out_valid_next = out_valid_reg;
        o_min_x_next   = o_min_x_reg;
        o_min_y_next   = o_min_y_reg;
        o_max_x_next   = o_max_x_reg;
        o_max_y_next   = o_max_y_reg;
        o_area_next    = o_area_reg;
        o_mid_x_next   = o_mid_x_reg;
        o_mid_y_next   = o_mid_y_reg;
        o_cent_x_next  = o_cent_x_reg;
        o_cent_y_next  = o_cent_y_reg;
        o_border_next  = o_border_reg;

        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:  width_next  = cfg_data;
                REG_IMAGE_HEIGHT: height_next = cfg_data;
                default:          width_next  = width_reg;
            endcase
        end

        if (in_fire)
        begin
            x_next    = run_start_x;
            y_next    = run_row;
            len_next  = len_clip;
            last_next = blob_last;
        end

        if (state_reg == ST_DIV_X && div_done)
            cent_x_next = div_quotient;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        if (out_load)
        begin
            out_valid_next = 1'b1;
            o_min_x_next   = acc_min_x;
            o_min_y_next   = acc_min_y;
            o_max_x_next   = acc_max_x;
            o_max_y_next   = acc_max_y;
            o_area_next    = acc_area;
            o_mid_x_next   = mid_x_full[COORD_BITS-1:0];
            o_mid_y_next   = mid_y_full[COORD_BITS-1:0];
            o_cent_x_next  = cent_x_reg;
            o_cent_y_next  = div_quotient;
            o_border_next  = acc_border;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            width_reg     <= FULL_SPAN;
            height_reg    <= FULL_SPAN;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            width_reg     <= width_next;
            height_reg    <= height_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg        <= x_next;
        y_reg        <= y_next;
        len_reg      <= len_next;
        last_reg     <= last_next;
        cent_x_reg   <= cent_x_next;
        o_min_x_reg  <= o_min_x_next;
        o_min_y_reg  <= o_min_y_next;
        o_max_x_reg  <= o_max_x_next;
        o_max_y_reg  <= o_max_y_next;
        o_area_reg   <= o_area_next;
        o_mid_x_reg  <= o_mid_x_next;
        o_mid_y_reg  <= o_mid_y_next;
        o_cent_x_reg <= o_cent_x_next;
        o_cent_y_reg <= o_cent_y_next;
        o_border_reg <= o_border_next;
    end

    assign out_valid      = out_valid_reg;
    assign box_min_x      = o_min_x_reg;
    assign box_min_y      = o_min_y_reg;
    assign box_max_x      = o_max_x_reg;
    assign box_max_y      = o_max_y_reg;
    assign blob_area      = o_area_reg;
    assign mid_x          = o_mid_x_reg;
    assign mid_y          = o_mid_y_reg;
    assign centroid_x     = o_cent_x_reg;
    assign centroid_y     = o_cent_y_reg;
    assign touches_border = o_border_reg;

endmodule

`default_nettype wire
